// ===== src/cuat_pkg.sv =====
// Shared types, codes and helper functions for the card identifier access table.
package cuat_pkg;

    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_REMOVE     = 3'd1;
    localparam logic [2:0] OP_SET_ENABLE = 3'd2;
    localparam logic [2:0] OP_LOOKUP     = 3'd3;
    localparam logic [2:0] OP_READ_ENTRY = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID_ARG = 3'd1;
    localparam logic [2:0] ST_INVALID_LEN = 3'd2;
    localparam logic [2:0] ST_DUPLICATE   = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd5;

    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_USER  = 2'd1;
    localparam logic [1:0] ROLE_ADMIN = 2'd2;

    localparam logic [3:0] LEN_SHORT = 4'd4;
    localparam logic [3:0] LEN_MID   = 4'd7;
    localparam logic [3:0] LEN_LONG  = 4'd10;

    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_ADD    = 2'd1;
    localparam logic [1:0] WR_MOVE   = 2'd2;
    localparam logic [1:0] WR_ENABLE = 2'd3;

    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_SCAN = 2'd1;
    localparam logic [1:0] RD_LAST = 2'd2;
    localparam logic [1:0] RD_IDX  = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  id_len;
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [1:0]  role_in;
        logic        enable_in;
        logic [7:0]  slot_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  role_out;
        logic        authorized;
        logic [8:0]  card_total;
        logic        entry_present;
        logic [63:0] entry_uid_low;
        logic [15:0] entry_uid_high;
        logic [3:0]  entry_id_len;
        logic [1:0]  entry_role;
        logic        entry_enabled;
    } t_out;

    typedef struct packed {
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [3:0]  id_len;
        logic [1:0]  role;
        logic        enable;
    } t_entry;

    typedef struct packed {
        logic       capture;
        logic       scan_start;
        logic [1:0] rd_sel;
        logic [1:0] wr_sel;
        logic       dec_count;
        logic       out_load;
        logic [2:0] status;
    } t_ctl_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       len_ok;
        logic       role_ok;
        logic       idx_ok;
        logic       full;
        logic       hit;
        logic       miss;
        logic       hit_last;
        logic       out_free;
    } t_ctl_sts;

    function automatic logic f_len_ok(input logic [3:0] len);
        return (len == LEN_SHORT) || (len == LEN_MID) || (len == LEN_LONG);
    endfunction

    function automatic logic [63:0] f_mask_low(input logic [3:0] len);
        logic [63:0] mask;
        if (len == LEN_SHORT) begin
            mask = 64'h0000_0000_FFFF_FFFF;
        end else if (len == LEN_MID) begin
            mask = 64'h00FF_FFFF_FFFF_FFFF;
        end else begin
            mask = 64'hFFFF_FFFF_FFFF_FFFF;
        end
        return mask;
    endfunction

    function automatic logic [15:0] f_mask_high(input logic [3:0] len);
        return (len == LEN_LONG) ? 16'hFFFF : 16'h0000;
    endfunction

endpackage

// ===== src/cuat_ctrl.sv =====
// Controller state machine that sequences each table operation.
module cuat_ctrl import cuat_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_ctl_sts i_sts,
    output logic     o_in_stall,
    output t_ctl_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_ADD_WR   = 4'd3;
    localparam logic [3:0] S_RM_RD    = 4'd4;
    localparam logic [3:0] S_RM_MV    = 4'd5;
    localparam logic [3:0] S_EN_WR    = 4'd6;
    localparam logic [3:0] S_RD_ISSUE = 4'd7;
    localparam logic [3:0] S_RD_WAIT  = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_status;
    logic [2:0] n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.rd_sel = RD_NONE;
        o_cmd.wr_sel = WR_NONE;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.op == OP_READ_ENTRY) begin
                    if (i_sts.idx_ok) begin
                        n_state = S_RD_ISSUE;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_FINISH;
                    end
                end else if (i_sts.op != OP_ADD && i_sts.op != OP_REMOVE &&
                             i_sts.op != OP_SET_ENABLE && i_sts.op != OP_LOOKUP) begin
                    n_status = ST_INVALID_ARG;
                    n_state  = S_FINISH;
                end else if (!i_sts.len_ok) begin
                    n_status = ST_INVALID_LEN;
                    n_state  = S_FINISH;
                end else if (i_sts.op == OP_ADD && !i_sts.role_ok) begin
                    n_status = ST_INVALID_ARG;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_sel = RD_SCAN;
                priority if (i_sts.hit) begin
                    priority case (i_sts.op)
                        OP_ADD: begin
                            n_status = ST_DUPLICATE;
                            n_state  = S_FINISH;
                        end
                        OP_REMOVE: begin
                            if (i_sts.hit_last) begin
                                o_cmd.dec_count = 1'b1;
                                n_status        = ST_OK;
                                n_state         = S_FINISH;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        OP_SET_ENABLE: begin
                            n_state = S_EN_WR;
                        end
                        default: begin
                            n_status = ST_OK;
                            n_state  = S_FINISH;
                        end
                    endcase
                end else if (i_sts.miss) begin
                    if (i_sts.op == OP_ADD) begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            n_state = S_ADD_WR;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_FINISH;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ADD_WR: begin
                o_cmd.wr_sel = WR_ADD;
                n_status     = ST_OK;
                n_state      = S_FINISH;
            end
            S_RM_RD: begin
                o_cmd.rd_sel = RD_LAST;
                n_state      = S_RM_MV;
            end
            S_RM_MV: begin
                o_cmd.wr_sel    = WR_MOVE;
                o_cmd.dec_count = 1'b1;
                n_status        = ST_OK;
                n_state         = S_FINISH;
            end
            S_EN_WR: begin
                o_cmd.wr_sel = WR_ENABLE;
                n_status     = ST_OK;
                n_state      = S_FINISH;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                n_status = ST_OK;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/cuat_datapath.sv =====
// Datapath with the entry memory, card count, scan pointer and result register.
module cuat_datapath import cuat_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in      i_in_data,
    input  logic     i_out_stall,
    input  t_ctl_cmd i_cmd,
    output t_ctl_sts o_sts,
    output logic     o_out_valid,
    output t_out     o_out_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_entry          r_mem [MAX_ENTRIES];
    t_in             r_req;
    t_in             n_req;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_addr;
    logic            r_rvalid;
    logic [IW-1:0]   r_raddr;
    t_entry          r_rdata;
    t_entry          r_hit;
    logic [IW-1:0]   r_hit_slot;
    t_out            r_out;
    t_out            n_out;
    logic            r_out_valid;

    logic [CW-1:0]   w_last;
    logic            w_match;
    logic            w_hit;
    logic            w_scan_more;
    logic            w_rd_en;
    logic [IW-1:0]   w_rd_addr;
    logic            w_wr_en;
    logic [IW-1:0]   w_wr_addr;
    t_entry          w_wr_data;
    logic            w_out_free;

    assign w_last      = r_count - CW'(1);
    assign w_match     = (r_rdata.id_len == r_req.id_len) &&
                         (r_rdata.uid_low == r_req.uid_low) &&
                         (r_rdata.uid_high == r_req.uid_high);
    assign w_hit       = r_rvalid && w_match;
    assign w_scan_more = (r_addr < r_count);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_req          = i_in_data;
        n_req.uid_low  = i_in_data.uid_low & f_mask_low(i_in_data.id_len);
        n_req.uid_high = i_in_data.uid_high & f_mask_high(i_in_data.id_len);
    end

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_addr[IW-1:0];
        unique case (i_cmd.rd_sel)
            RD_SCAN: begin
                w_rd_en   = w_scan_more;
                w_rd_addr = r_addr[IW-1:0];
            end
            RD_LAST: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_last[IW-1:0];
            end
            RD_IDX: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_req.slot_index[IW-1:0];
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_hit_slot;
        w_wr_data = r_hit;
        unique case (i_cmd.wr_sel)
            WR_ADD: begin
                w_wr_en            = 1'b1;
                w_wr_addr          = r_count[IW-1:0];
                w_wr_data.uid_low  = r_req.uid_low;
                w_wr_data.uid_high = r_req.uid_high;
                w_wr_data.id_len   = r_req.id_len;
                w_wr_data.role     = r_req.role_in;
                w_wr_data.enable   = 1'b1;
            end
            WR_MOVE: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_rdata;
            end
            WR_ENABLE: begin
                w_wr_en          = 1'b1;
                w_wr_data.enable = r_req.enable_in;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
            r_raddr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_addr      <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_sel == WR_ADD) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= w_last;
            end
            if (i_cmd.scan_start) begin
                r_addr   <= '0;
                r_rvalid <= 1'b0;
            end else if (i_cmd.rd_sel == RD_SCAN) begin
                r_rvalid <= w_scan_more;
                if (w_scan_more) begin
                    r_addr <= r_addr + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= n_req;
        end
        if (i_cmd.rd_sel == RD_SCAN && w_hit) begin
            r_hit      <= r_rdata;
            r_hit_slot <= r_raddr;
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.status     = i_cmd.status;
        n_out.card_total = 9'(r_count);
        if (r_req.operation == OP_LOOKUP && i_cmd.status == ST_OK && r_hit.enable) begin
            n_out.role_out   = r_hit.role;
            n_out.authorized = (r_hit.role == ROLE_USER) || (r_hit.role == ROLE_ADMIN);
        end
        if (r_req.operation == OP_READ_ENTRY && i_cmd.status == ST_OK) begin
            n_out.entry_present  = 1'b1;
            n_out.entry_uid_low  = r_rdata.uid_low;
            n_out.entry_uid_high = r_rdata.uid_high;
            n_out.entry_id_len   = r_rdata.id_len;
            n_out.entry_role     = r_rdata.role;
            n_out.entry_enabled  = r_rdata.enable;
        end
    end

    assign o_sts.op       = r_req.operation;
    assign o_sts.len_ok   = f_len_ok(r_req.id_len);
    assign o_sts.role_ok  = (r_req.role_in == ROLE_USER) || (r_req.role_in == ROLE_ADMIN);
    assign o_sts.idx_ok   = ({1'b0, r_req.slot_index} < 9'(r_count));
    assign o_sts.full     = (r_count == CW'(MAX_ENTRIES));
    assign o_sts.hit      = w_hit;
    assign o_sts.miss     = !r_rvalid && !w_scan_more;
    assign o_sts.hit_last = (r_raddr == w_last[IW-1:0]);
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/card_uid_access_table.sv =====
// Top level of the card identifier access table.
// The table holds up to MAX_ENTRIES cards of 4, 7 or 10 byte identifiers with a role and an
// enable flag, packed from slot zero in a memory with separate read and write addresses. One
// operation is handled at a time. Add, remove, set enable and lookup search the stored cards
// one per cycle behind a registered memory read, and a search ends at the first matching card
// or after the last stored card. A lookup, a duplicate add, a full table, a removal of the
// last slot or any other miss then loads its result; a set enable or a successful add first
// writes the entry, and a removal that moves the last card into the freed slot first reads
// the last card and then writes it. Read entry reads the requested slot, and an operation
// rejected for its code, length, role or slot index is answered after decoding. The next
// transaction is accepted in the cycle after a result is loaded; a finished result waits in
// an output register while the next transaction is processed, and only a result that finds
// the previous one still waiting holds the block until the output side takes it.
module card_uid_access_table import cuat_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    cuat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    cuat_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
